// ===== design/fbrf_pkg.sv =====
// Shared types, constants and codes for the framebuffer rectangle fill block.
`default_nettype none

package fbrf_pkg;

   // Screen geometry and the derived framebuffer size.
   localparam int SCREEN_WIDTH  = 128;
   localparam int SCREEN_HEIGHT = 160;
   localparam int STORE_DEPTH   = SCREEN_WIDTH * SCREEN_HEIGHT;
   localparam int ADDR_W        = $clog2(STORE_DEPTH);
   localparam int COORD_W       = 8;
   localparam int COLOR_W       = 16;

   // Screen limits one bit wider than a coordinate, so that a sum can be compared.
   localparam logic [COORD_W:0] SCREEN_WIDTH_EXT  = (COORD_W + 1)'(SCREEN_WIDTH);
   localparam logic [COORD_W:0] SCREEN_HEIGHT_EXT = (COORD_W + 1)'(SCREEN_HEIGHT);

   // Request action codes.
   localparam logic ACT_FILL = 1'b0;
   localparam logic ACT_READ = 1'b1;

   // Result status codes.
   localparam logic STATUS_DONE       = 1'b0;
   localparam logic STATUS_OFF_SCREEN = 1'b1;

   // One request word.
   typedef struct packed {
      logic               action;
      logic [COORD_W-1:0] x_origin;
      logic [COORD_W-1:0] y_origin;
      logic [COORD_W-1:0] rect_width;
      logic [COORD_W-1:0] rect_height;
      logic [COLOR_W-1:0] fill_color;
   } req_type;

   // One response word.
   typedef struct packed {
      logic [COLOR_W-1:0] pixel_value;
      logic               status;
   } rsp_type;

   // Command classes produced by the front end.
   typedef enum logic [1:0] {
      CMD_FILL,
      CMD_READ,
      CMD_REJECT
   } cmd_kind_type;

   // A classified, clipped command as it waits for the back end.
   typedef struct packed {
      cmd_kind_type       kind;
      logic [ADDR_W-1:0]  base_addr;
      logic [COORD_W-1:0] width;
      logic [COORD_W-1:0] height;
      logic [COLOR_W-1:0] color;
   } cmd_type;

   // Back end sequencer states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FILL,
      ST_DONE
   } state_type;

endpackage

`default_nettype wire

// ===== design/fbrf_front.sv =====
// Front end: classifies each request, clips the rectangle and forms its start address.
`default_nettype none

module fbrf_front (
   input  wire fbrf_pkg::req_type req_data,
   input  wire                    req_push,
   input  wire                    cmd_full,
   output logic                   req_full,
   output logic                   cmd_push,
   output fbrf_pkg::cmd_type      cmd_data
);
   import fbrf_pkg::*;

   logic [COORD_W:0] x_ext;
   logic [COORD_W:0] y_ext;
   logic [COORD_W:0] x_end;
   logic [COORD_W:0] y_end;
   logic             off_screen;

   // A request is taken whenever the command queue has room.
   assign req_full = cmd_full;
   assign cmd_push = req_push && !cmd_full;

   // Edge tests on widened coordinates.
   assign x_ext      = {1'b0, req_data.x_origin};
   assign y_ext      = {1'b0, req_data.y_origin};
   assign x_end      = x_ext + {1'b0, req_data.rect_width};
   assign y_end      = y_ext + {1'b0, req_data.rect_height};
   assign off_screen = (x_ext >= SCREEN_WIDTH_EXT) || (y_ext >= SCREEN_HEIGHT_EXT);

   // Build the command word; the rectangle is cut back at the right and bottom edges.
   always_comb begin
      if (off_screen) begin
         cmd_data.kind = CMD_REJECT;
      end else if (req_data.action == ACT_READ) begin
         cmd_data.kind = CMD_READ;
      end else begin
         cmd_data.kind = CMD_FILL;
      end
      cmd_data.base_addr = ADDR_W'(ADDR_W'(req_data.y_origin) * ADDR_W'(SCREEN_WIDTH)
                                  + ADDR_W'(req_data.x_origin));
      cmd_data.width  = (x_end > SCREEN_WIDTH_EXT) ?
                        COORD_W'(SCREEN_WIDTH_EXT - x_ext) : req_data.rect_width;
      cmd_data.height = (y_end > SCREEN_HEIGHT_EXT) ?
                        COORD_W'(SCREEN_HEIGHT_EXT - y_ext) : req_data.rect_height;
      cmd_data.color  = req_data.fill_color;
   end

endmodule

`default_nettype wire

// ===== design/fbrf_cmd_queue.sv =====
// Two-entry command queue between the front end and the back end.
`default_nettype none

module fbrf_cmd_queue (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    push,
   input  wire fbrf_pkg::cmd_type push_data,
   output logic                   full,
   input  wire                    pop,
   output logic                   empty,
   output fbrf_pkg::cmd_type      pop_data
);
   import fbrf_pkg::*;

   cmd_type    entries_ff [2];
   logic       wr_ptr_ff;
   logic       rd_ptr_ff;
   logic [1:0] count_ff;
   logic [1:0] count_in;
   logic       do_push;
   logic       do_pop;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 2'd1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 2'd1;
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== design/fbrf_back.sv =====
// Back end: framebuffer memory, fill sequencer and the response register.
`default_nettype none

module fbrf_back (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    cmd_empty,
   input  wire fbrf_pkg::cmd_type cmd_data,
   output logic                   cmd_pop,
   output logic                   rsp_empty,
   input  wire                    rsp_pop,
   output fbrf_pkg::rsp_type      rsp_data
);
   import fbrf_pkg::*;

   logic [COLOR_W-1:0] mem [STORE_DEPTH];

   state_type          state_ff;
   state_type          state_in;
   cmd_kind_type       kind_ff;
   logic [ADDR_W-1:0]  addr_ff;
   logic [ADDR_W-1:0]  row_base_ff;
   logic [ADDR_W-1:0]  next_row;
   logic [COORD_W-1:0] col_ff;
   logic [COORD_W-1:0] row_ff;
   logic [COORD_W-1:0] width_ff;
   logic [COLOR_W-1:0] color_ff;
   logic [COLOR_W-1:0] rd_data_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            result;
   logic               slot_free;
   logic               rd_en;
   logic               wr_en;
   logic               rsp_load;
   logic               last_col;
   logic               last_pixel;
   logic               fill_nonempty;

   assign slot_free     = !rsp_valid_ff || rsp_pop;
   assign last_col      = (col_ff == COORD_W'(1));
   assign last_pixel    = last_col && (row_ff == COORD_W'(1));
   assign next_row      = row_base_ff + ADDR_W'(SCREEN_WIDTH);
   assign fill_nonempty = (cmd_data.kind == CMD_FILL) &&
                          (cmd_data.width != '0) && (cmd_data.height != '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               state_in = fill_nonempty ? ST_FILL : ST_DONE;
            end
         end
         ST_FILL: begin
            if (last_pixel) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // State outputs.
   always_comb begin
      cmd_pop  = 1'b0;
      wr_en    = 1'b0;
      rsp_load = 1'b0;
      unique case (state_ff)
         ST_IDLE: cmd_pop  = !cmd_empty;
         ST_FILL: wr_en    = 1'b1;
         ST_DONE: rsp_load = slot_free;
         default: ;
      endcase
   end

   assign rd_en = cmd_pop && (cmd_data.kind == CMD_READ);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Command load and the raster walk: one pixel per cycle, row by row.
   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         kind_ff     <= cmd_data.kind;
         addr_ff     <= cmd_data.base_addr;
         row_base_ff <= cmd_data.base_addr;
         col_ff      <= cmd_data.width;
         row_ff      <= cmd_data.height;
         width_ff    <= cmd_data.width;
         color_ff    <= cmd_data.color;
      end else if (wr_en) begin
         if (last_col) begin
            row_base_ff <= next_row;
            addr_ff     <= next_row;
            col_ff      <= width_ff;
            row_ff      <= row_ff - COORD_W'(1);
         end else begin
            addr_ff <= addr_ff + ADDR_W'(1);
            col_ff  <= col_ff - COORD_W'(1);
         end
      end
   end

   // Framebuffer write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr_ff] <= color_ff;
      end
   end

   // Framebuffer read port with registered data.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[cmd_data.base_addr];
      end
   end

   // Response contents by command class.
   always_comb begin
      unique case (kind_ff)
         CMD_READ: begin
            result.pixel_value = rd_data_ff;
            result.status      = STATUS_DONE;
         end
         CMD_REJECT: begin
            result.pixel_value = '0;
            result.status      = STATUS_OFF_SCREEN;
         end
         default: begin
            result.pixel_value = '0;
            result.status      = STATUS_DONE;
         end
      endcase
   end

   // Response register; the next command may run while a word waits here.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= result;
      end
   end

   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

`default_nettype wire

// ===== design/framebuffer_rectangle_fill.sv =====
// Top level of the framebuffer rectangle fill block.
//
//   Channel   Ports                          Word
//   request   req_push, req_full, req_data    action, origin, size, fill color
//   response  rsp_empty, rsp_pop, rsp_data    pixel value, status
//
// A fill of a clipped w by h rectangle makes w*h framebuffer writes in the FILL state,
// one write per cycle; a read or an off-screen request passes only IDLE and DONE.
// The single-port write and single read port of the framebuffer set that pace.
// Reset is synchronous; it empties the command queue and the response register.
// The framebuffer is not cleared and needs no pass after reset.
// A two-entry queue holds requests while the back end works or waits on rsp_pop.
`default_nettype none

module framebuffer_rectangle_fill (
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    req_push,
   output logic                   req_full,
   input  wire fbrf_pkg::req_type req_data,
   output logic                   rsp_empty,
   input  wire                    rsp_pop,
   output fbrf_pkg::rsp_type      rsp_data
);
   import fbrf_pkg::*;

   cmd_type front_cmd;
   cmd_type queue_cmd;
   logic    cmd_push;
   logic    cmd_full;
   logic    cmd_empty;
   logic    cmd_pop;

   fbrf_front u_front (
      .req_data (req_data),
      .req_push (req_push),
      .cmd_full (cmd_full),
      .req_full (req_full),
      .cmd_push (cmd_push),
      .cmd_data (front_cmd)
   );

   fbrf_cmd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (front_cmd),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .empty     (cmd_empty),
      .pop_data  (queue_cmd)
   );

   fbrf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_empty (cmd_empty),
      .cmd_data  (queue_cmd),
      .cmd_pop   (cmd_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_data  (rsp_data)
   );

endmodule

`default_nettype wire

// ===== design/fbrf_checker.sv =====
// Port-level checks for the framebuffer rectangle fill block and their binding.
`default_nettype none

module fbrf_checker (
   input wire                    clock,
   input wire                    reset,
   input wire                    req_push,
   input wire                    req_full,
   input wire fbrf_pkg::req_type req_data,
   input wire                    rsp_empty,
   input wire                    rsp_pop,
   input wire fbrf_pkg::rsp_type rsp_data
);
   import fbrf_pkg::*;

   // Reset leaves no response pending and the request side open.
   assert property (@(posedge clock) reset |=> rsp_empty && !req_full)
      else $error("response or full flag not cleared by reset");

   // A waiting response is neither dropped nor changed until it is popped.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && !rsp_pop |=> !rsp_empty && $stable(rsp_data))
      else $error("waiting response lost or changed");

   // The response side only drains through a pop.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_empty) |-> $past(rsp_pop))
      else $error("response vanished without a pop");

   // A rejected request never reports pixel data.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_empty && (rsp_data.status == STATUS_OFF_SCREEN) |-> rsp_data.pixel_value == '0)
      else $error("off-screen response carries pixel data");

   // The handshake flags are always known once reset is released.
   assert property (@(posedge clock) disable iff (reset)
      !$isunknown(req_full) && !$isunknown(rsp_empty))
      else $error("handshake flag unknown after reset");

endmodule

bind framebuffer_rectangle_fill fbrf_checker u_fbrf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .req_data  (req_data),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire
